/* rtl/core/rbr_pkg.sv */
`default_nettype none

package rbr_pkg;

   // Sizes of the byte store and of the read position
   localparam int BUFFER_BYTES  = 4096;
   localparam int ADDR_W        = $clog2(BUFFER_BYTES);
   localparam int POS_W         = ADDR_W + 1;
   localparam int MAX_READ_BITS = 32;
   localparam int CNT_W         = 16;
   localparam int VALUE_W       = 32;

   // Golomb prefix length at which the value is no longer representable
   localparam int GOLOMB_MAX_ZEROS = 32;
   localparam int ZEROS_W          = $clog2(GOLOMB_MAX_ZEROS + 1);

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   // Emulation prevention byte and the zero run that arms it
   localparam logic [7:0] EMU_BYTE  = 8'h03;
   localparam logic [1:0] ZRUN_ARM  = 2'd2;
   localparam logic [2:0] BIT_MSB   = 3'd7;

   // Request codes
   localparam logic [2:0] MODE_RESTART = 3'd0;
   localparam logic [2:0] MODE_APPEND  = 3'd1;
   localparam logic [2:0] MODE_GET     = 3'd2;
   localparam logic [2:0] MODE_PEEK    = 3'd3;
   localparam logic [2:0] MODE_SKIP    = 3'd4;
   localparam logic [2:0] MODE_UE      = 3'd5;
   localparam logic [2:0] MODE_SE      = 3'd6;

   // Status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_NODATA = 2'd1;
   localparam logic [1:0] STAT_LONG   = 2'd2;
   localparam logic [1:0] STAT_COUNT  = 2'd3;

   typedef enum logic [3:0] {
      OP_RESTART,
      OP_APPEND,
      OP_GET,
      OP_PEEK,
      OP_SKIP,
      OP_UE,
      OP_SE,
      OP_BAD_COUNT,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [7:0]       data_byte;
      logic [CNT_W-1:0] bit_count;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

`default_nettype wire

/* rtl/core/rbsp_bit_reader_exp_golomb.sv */
// Channel   | Ports                                        | Transfer
// ----------+----------------------------------------------+---------------------------------
// request   | start, busy, req_mode, req_data_byte,        | edge with start high, busy low
//           | req_bit_count                                |
// response  | rsp_strobe, rsp_value, rsp_status            | edge ending the strobe cycle
//
// Restart, append, bad count and unused codes are answered from the executor's idle state.
// A read goes from idle through the fetch state to the bit state, which takes the bits;
// each byte entered passes through the fetch state again for the store's registered read port.
// Two requests queue ahead of the executor; busy is high while both slots are full.
// Synchronous reset empties the store and the queue and rewinds the cursor.
// The receiver cannot stall: rsp_strobe marks each result for one cycle.
`default_nettype none

module rbsp_bit_reader_exp_golomb
   import rbr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_mode,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic [CNT_W-1:0]   req_bit_count,
   output logic                    rsp_strobe,
   output logic [VALUE_W-1:0]      rsp_value,
   output logic [1:0]              rsp_status
);

   queue_head_type head;
   logic           pop;

   // Front: classify requests and queue them
   rbr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .req_bit_count (req_bit_count),
      .pop           (pop),
      .head          (head)
   );

   // Back: byte store and bit engine
   rbr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

endmodule

`default_nettype wire

/* rtl/core/rbr_front.sv */
`default_nettype none

module rbr_front
   import rbr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [2:0]       req_mode,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic [CNT_W-1:0] req_bit_count,
   input  wire logic             pop,
   output queue_head_type        head
);

   cmd_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0]   fill_ff, fill_in;
   logic                 push;
   cmd_type              cmd;
   logic                 count_too_big;

   // Classify the request into an operation
   always_comb begin
      count_too_big = req_bit_count > CNT_W'(MAX_READ_BITS);
      cmd.data_byte = req_data_byte;
      cmd.bit_count = req_bit_count;
      case (req_mode)
         MODE_RESTART: cmd.op = OP_RESTART;
         MODE_APPEND:  cmd.op = OP_APPEND;
         MODE_GET:     cmd.op = count_too_big ? OP_BAD_COUNT : OP_GET;
         MODE_PEEK:    cmd.op = count_too_big ? OP_BAD_COUNT : OP_PEEK;
         MODE_SKIP:    cmd.op = OP_SKIP;
         MODE_UE:      cmd.op = OP_UE;
         MODE_SE:      cmd.op = OP_SE;
         default:      cmd.op = OP_NONE;
      endcase
   end

   assign busy = fill_ff == QFILL_W'(QUEUE_DEPTH);
   assign push = start && !busy;

   // Queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue slots carry payload only
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign head.valid = fill_ff != '0;
   assign head.cmd   = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* rtl/core/rbr_back.sv */
`default_nettype none

module rbr_back
   import rbr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire queue_head_type     head,
   output logic                    pop,
   output logic                    rsp_strobe,
   output logic [VALUE_W-1:0]      rsp_value,
   output logic [1:0]              rsp_status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_BITS
   } state_type;

   // Byte store and, per byte, a mark that the following byte is an emulation byte
   logic [7:0] byte_mem [BUFFER_BYTES];
   logic       next_emu_mem [BUFFER_BYTES];

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [POS_W-1:0]   byte_count_ff, byte_count_in;
   logic [POS_W-1:0]   byte_pos_ff, byte_pos_in;
   logic [2:0]         bit_pos_ff, bit_pos_in;
   logic [1:0]         zrun_ff, zrun_in;
   logic [POS_W-1:0]   cp_ff, cp_in;
   logic [2:0]         cb_ff, cb_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [ZEROS_W-1:0] zeros_ff, zeros_in;
   logic               prefix_ff, prefix_in;
   logic               long_ff, long_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic [7:0]         rd_byte_ff;
   logic               rd_next_emu_ff;
   logic               byte_wr_en;
   logic               emu_wr_en;
   logic               emu_wr_data;
   logic [ADDR_W-1:0]  emu_wr_addr;

   logic               need_bit;
   logic               no_data;
   logic               bit_now;
   logic [POS_W-1:0]   cp_step;
   logic [POS_W-1:0]   cp_cross;
   logic [VALUE_W-1:0] ue_value;
   logic [VALUE_W-1:0] se_half;
   logic [VALUE_W-1:0] done_value;

   // Byte store: one write port for appends, registered read at the cursor
   always_ff @(posedge clock) begin
      if (byte_wr_en) begin
         byte_mem[byte_count_ff[ADDR_W-1:0]] <= head.cmd.data_byte;
      end
      rd_byte_ff <= byte_mem[cp_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (emu_wr_en) begin
         next_emu_mem[emu_wr_addr] <= emu_wr_data;
      end
      rd_next_emu_ff <= next_emu_mem[cp_ff[ADDR_W-1:0]];
   end

   // Bit step: next bit and cursor after it, passing over an emulation byte
   always_comb begin
      need_bit = prefix_ff || (rem_ff != '0);
      no_data  = cp_ff >= byte_count_ff;
      bit_now  = rd_byte_ff[cb_ff];
      cp_step  = cp_ff + POS_W'(1);
      cp_cross = ((cp_step < byte_count_ff) && rd_next_emu_ff) ? cp_ff + POS_W'(2)
                                                                  : cp_step;
   end

   // Result of a finished read
   always_comb begin
      ue_value = val_ff - VALUE_W'(1);
      se_half  = val_ff >> 1;
      case (op_ff)
         OP_GET, OP_PEEK: done_value = val_ff;
         OP_UE:           done_value = long_ff ? '0 : ue_value;
         OP_SE:           done_value = long_ff ? '0 : (val_ff[0] ? '0 - se_half : se_half);
         default:         done_value = '0;
      endcase
   end

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      byte_count_in = byte_count_ff;
      byte_pos_in   = byte_pos_ff;
      bit_pos_in    = bit_pos_ff;
      zrun_in       = zrun_ff;
      cp_in         = cp_ff;
      cb_in         = cb_ff;
      rem_in        = rem_ff;
      val_in        = val_ff;
      zeros_in      = zeros_ff;
      prefix_in     = prefix_ff;
      long_in       = long_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      pop           = 1'b0;
      byte_wr_en    = 1'b0;
      emu_wr_en     = 1'b0;
      emu_wr_data   = 1'b0;
      emu_wr_addr   = byte_count_ff[ADDR_W-1:0] - 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop       = 1'b1;
               op_in     = head.cmd.op;
               cp_in     = byte_pos_ff;
               cb_in     = bit_pos_ff;
               rem_in    = head.cmd.bit_count;
               val_in    = '0;
               zeros_in  = '0;
               long_in   = 1'b0;
               prefix_in = (head.cmd.op == OP_UE) || (head.cmd.op == OP_SE);
               case (head.cmd.op)
                  OP_RESTART: begin
                     byte_count_in = '0;
                     byte_pos_in   = '0;
                     bit_pos_in    = BIT_MSB;
                     zrun_in       = '0;
                     rsp_strobe_in = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = STAT_OK;
                  end
                  OP_APPEND: begin
                     // A full store drops the byte
                     if (byte_count_ff < POS_W'(BUFFER_BYTES)) begin
                        byte_wr_en    = 1'b1;
                        emu_wr_en     = byte_count_ff != '0;
                        emu_wr_data   = (zrun_ff == ZRUN_ARM) &&
                                        (head.cmd.data_byte == EMU_BYTE);
                        byte_count_in = byte_count_ff + POS_W'(1);
                        if (head.cmd.data_byte == 8'h00) begin
                           zrun_in = (zrun_ff == ZRUN_ARM) ? ZRUN_ARM : zrun_ff + 1'b1;
                        end else begin
                           zrun_in = '0;
                        end
                     end
                     rsp_strobe_in = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = STAT_OK;
                  end
                  OP_GET, OP_PEEK, OP_SKIP, OP_UE, OP_SE: begin
                     state_in = S_FETCH;
                  end
                  OP_BAD_COUNT: begin
                     rsp_strobe_in = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = STAT_COUNT;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = STAT_OK;
                  end
               endcase
            end
         end

         // Store read latency at a new byte
         S_FETCH: begin
            state_in = S_BITS;
         end

         S_BITS: begin
            if (!need_bit) begin
               // Done: commit the cursor unless this is a peek
               if (op_ff != OP_PEEK) begin
                  byte_pos_in = cp_ff;
                  bit_pos_in  = cb_ff;
               end
               rsp_strobe_in = 1'b1;
               rsp_value_in  = done_value;
               rsp_status_in = long_ff ? STAT_LONG : STAT_OK;
               state_in      = S_IDLE;
            end else if (no_data) begin
               // Position stays where the request found it
               rsp_strobe_in = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = STAT_NODATA;
               state_in      = S_IDLE;
            end else begin
               if (cb_ff == '0) begin
                  cb_in    = BIT_MSB;
                  cp_in    = cp_cross;
                  state_in = S_FETCH;
               end else begin
                  cb_in = cb_ff - 1'b1;
               end
               if (prefix_ff) begin
                  if (bit_now) begin
                     prefix_in = 1'b0;
                     if (zeros_ff == ZEROS_W'(GOLOMB_MAX_ZEROS)) begin
                        long_in = 1'b1;
                        rem_in  = '0;
                     end else begin
                        rem_in = CNT_W'(zeros_ff);
                        val_in = VALUE_W'(1);
                     end
                  end else if (zeros_ff != ZEROS_W'(GOLOMB_MAX_ZEROS)) begin
                     zeros_in = zeros_ff + 1'b1;
                  end
               end else begin
                  rem_in = rem_ff - 1'b1;
                  val_in = {val_ff[VALUE_W-2:0], bit_now};
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         byte_count_ff <= '0;
         byte_pos_ff   <= '0;
         bit_pos_ff    <= BIT_MSB;
         zrun_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         byte_count_ff <= byte_count_in;
         byte_pos_ff   <= byte_pos_in;
         bit_pos_ff    <= bit_pos_in;
         zrun_ff       <= zrun_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff         <= op_in;
      cp_ff         <= cp_in;
      cb_ff         <= cb_in;
      rem_ff        <= rem_in;
      val_ff        <= val_in;
      zeros_ff      <= zeros_in;
      prefix_ff     <= prefix_in;
      long_ff       <= long_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

/* rtl/core/rbr_checker.sv */
`default_nettype none

module rbr_checker
   import rbr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic               rsp_strobe,
   input  wire logic [VALUE_W-1:0] rsp_value,
   input  wire logic [1:0]         rsp_status
);

   // Reset leaves an empty queue and no result in flight
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("busy or strobe after reset");

   // Any failing status carries a zero value
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STAT_OK) |-> rsp_value == '0)
      else $error("nonzero value with failing status");

   // The queue only fills up through a transfer
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a request transfer");

endmodule

bind rbsp_bit_reader_exp_golomb rbr_checker u_rbr_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_value  (rsp_value),
   .rsp_status (rsp_status)
);

`default_nettype wire
